FILE: hdl/qmsm_pkg.sv
package qmsm_pkg;

    // Default and legal range of the stick sample width.
    localparam int SAMPLE_BITS_DEF = 10;
    localparam int SAMPLE_BITS_MIN = 8;
    localparam int SAMPLE_BITS_MAX = 12;

    // Widths of fixed fields.
    localparam int SPEED_W  = 8;
    localparam int MOTORS   = 4;
    localparam int MIDX_W   = 2;
    localparam int DZ_W     = 9;
    localparam int GAIN_W   = 8;
    localparam int ACTION_W = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_STICK   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ASCEND  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DESCEND = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DZ_ABOVE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DZ_BELOW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIMB    = 2'd3;

    // Configuration reset values.
    localparam logic [DZ_W-1:0]    DZ_ABOVE_RST = 9'd70;
    localparam logic [DZ_W-1:0]    DZ_BELOW_RST = 9'd50;
    localparam logic [GAIN_W-1:0]  GAIN_RST     = 8'd20;
    localparam logic [SPEED_W-1:0] CLIMB_RST    = 8'd20;

    // State reset values.
    localparam logic [SPEED_W-1:0] SPEED_RST = 8'd0;
    localparam logic [SPEED_W-1:0] SENT_RST  = 8'd10;

    // Motor index of the final command in a run.
    localparam logic [MIDX_W-1:0] MOTOR_LAST = 2'd3;

    // A set bit means that motor subtracts on positive deflection.
    localparam logic [MOTORS-1:0] HOR_SUB_MASK = 4'b0101;
    localparam logic [MOTORS-1:0] VER_SUB_MASK = 4'b0011;

    typedef logic [MOTORS-1:0][SPEED_W-1:0] t_speeds;

    // Correction of one axis, as handed to the mixing stage.
    typedef struct packed {
        logic               active;
        logic               positive;
        logic [SPEED_W-1:0] amount;
    } t_corr;

    // Add or subtract with saturation to the speed range.
    function automatic logic [SPEED_W-1:0] sat_step(
        input logic [SPEED_W-1:0] speed,
        input logic [SPEED_W-1:0] amount,
        input logic               sub
    );
        logic [SPEED_W:0] sum;
        sum = {1'b0, speed} + {1'b0, amount};
        if (sub) begin
            sat_step = (speed < amount) ? '0 : speed - amount;
        end else begin
            sat_step = sum[SPEED_W] ? '1 : sum[SPEED_W-1:0];
        end
    endfunction

endpackage

FILE: hdl/qmsm_axis.sv
// Dead zone test and correction size for one stick axis.
module qmsm_axis #(
    parameter int SAMPLE_BITS = qmsm_pkg::SAMPLE_BITS_DEF
) (
    input  logic [SAMPLE_BITS-1:0]        i_sample,
    input  logic [qmsm_pkg::DZ_W-1:0]     i_dz_above,
    input  logic [qmsm_pkg::DZ_W-1:0]     i_dz_below,
    input  logic [qmsm_pkg::GAIN_W-1:0]   i_gain,
    output qmsm_pkg::t_corr               o_corr
);

    // Compare width holds the centre plus the widest dead zone.
    localparam int CW    = SAMPLE_BITS + 4;
    localparam int PW    = SAMPLE_BITS + qmsm_pkg::GAIN_W;
    localparam int SHIFT = SAMPLE_BITS - 1;

    localparam logic [CW-1:0]          CENTRE_C = CW'(1) << SHIFT;
    localparam logic [SAMPLE_BITS-1:0] CENTRE_S = SAMPLE_BITS'(1) << SHIFT;

    logic [CW-1:0]          sample_c;
    logic                   pos_hit;
    logic                   neg_hit;
    logic [SAMPLE_BITS-1:0] offset;
    logic [PW-1:0]          product;

    assign sample_c = CW'(i_sample);
    assign pos_hit  = sample_c > (CENTRE_C + CW'(i_dz_above));
    assign neg_hit  = (sample_c + CW'(i_dz_below)) < CENTRE_C;

    // Distance from the centre on the side that triggered.
    assign offset  = pos_hit ? (i_sample - CENTRE_S) : (CENTRE_S - i_sample);
    assign product = PW'(offset) * PW'(i_gain);

    // Dividing by the centre is a shift; the result never exceeds the gain.
    assign o_corr.active   = pos_hit || neg_hit;
    assign o_corr.positive = pos_hit;
    assign o_corr.amount   = product[SHIFT +: qmsm_pkg::SPEED_W];

endmodule

FILE: hdl/qmsm_mixer.sv
// Motor speed state, mixing of both axes and climb steps, change detection.
module qmsm_mixer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_fire,
    input  logic [qmsm_pkg::ACTION_W-1:0]     i_action,
    input  qmsm_pkg::t_corr                   i_hor,
    input  qmsm_pkg::t_corr                   i_ver,
    input  logic [qmsm_pkg::SPEED_W-1:0]      i_climb,
    output logic                              o_changed,
    output logic                              o_load,
    output qmsm_pkg::t_speeds                 o_speeds
);

    qmsm_pkg::t_speeds r_speeds, n_speeds;
    qmsm_pkg::t_speeds r_sent;
    qmsm_pkg::t_speeds after_h, after_v;

    // Horizontal axis first, then vertical on the result.
    always_comb begin
        for (int m = 0; m < qmsm_pkg::MOTORS; m++) begin
            after_h[m] = i_hor.active
                ? qmsm_pkg::sat_step(r_speeds[m], i_hor.amount,
                                     qmsm_pkg::HOR_SUB_MASK[m] ^ !i_hor.positive)
                : r_speeds[m];
            after_v[m] = i_ver.active
                ? qmsm_pkg::sat_step(after_h[m], i_ver.amount,
                                     qmsm_pkg::VER_SUB_MASK[m] ^ !i_ver.positive)
                : after_h[m];
        end
    end

    // Select the new speeds by action; the unused code leaves them alone.
    always_comb begin
        n_speeds = r_speeds;
        unique case (i_action)
            qmsm_pkg::ACT_STICK: begin
                n_speeds = after_v;
            end
            qmsm_pkg::ACT_ASCEND: begin
                for (int m = 0; m < qmsm_pkg::MOTORS; m++) begin
                    n_speeds[m] = qmsm_pkg::sat_step(r_speeds[m], i_climb, 1'b0);
                end
            end
            qmsm_pkg::ACT_DESCEND: begin
                for (int m = 0; m < qmsm_pkg::MOTORS; m++) begin
                    n_speeds[m] = qmsm_pkg::sat_step(r_speeds[m], i_climb, 1'b1);
                end
            end
            default: begin
                n_speeds = r_speeds;
            end
        endcase
    end

    assign o_changed = (i_action == qmsm_pkg::ACT_STICK) && (after_v != r_sent);
    assign o_load    = i_fire && o_changed;
    assign o_speeds  = n_speeds;

    // Speed state and the copy of the last commands sent.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < qmsm_pkg::MOTORS; m++) begin
                r_speeds[m] <= qmsm_pkg::SPEED_RST;
                r_sent[m]   <= qmsm_pkg::SENT_RST;
            end
        end else if (i_fire) begin
            r_speeds <= n_speeds;
            if (o_changed) begin
                r_sent <= n_speeds;
            end
        end
    end

endmodule

FILE: hdl/qmsm_out_seq.sv
// Holds one run of four speed commands and hands them out in motor order.
module qmsm_out_seq (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  qmsm_pkg::t_speeds                 i_speeds,
    input  logic                              i_stall,
    output logic                              o_valid,
    output logic [qmsm_pkg::MIDX_W-1:0]       o_index,
    output logic [qmsm_pkg::SPEED_W-1:0]      o_speed,
    output logic                              o_last,
    output logic                              o_free
);

    qmsm_pkg::t_speeds                r_buf;
    logic [qmsm_pkg::MIDX_W-1:0]      r_idx;
    logic                             r_valid;

    assign o_valid = r_valid;
    assign o_index = r_idx;
    assign o_speed = r_buf[r_idx];
    assign o_last  = (r_idx == qmsm_pkg::MOTOR_LAST);

    // A new run may load as the last command of the current one transfers.
    assign o_free = !r_valid || (o_last && !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (r_valid && !i_stall) begin
            if (o_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // Command buffer needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_speeds;
        end
    end

endmodule

FILE: hdl/quad_motor_stick_mixer.sv
// Channel   Direction  Handshake                   Payload
// input     in         i_in_valid / o_in_stall     i_action, i_hor_sample, i_ver_sample
// output    out        o_out_valid / i_out_stall   o_motor_index, o_motor_speed,
//                                                  o_last_of_run
// config    in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// An item is accepted every cycle while o_in_stall is low. Stage one registers the
// item and computes the axis corrections (one multiplier per axis); stage two applies
// them to the speeds. A changed stick sample gives four commands from the output
// buffer; a further changed sample waits in stage two while that run is in flight.
// Reset (synchronous, active low) restores the register defaults, zero speeds
// and a last-sent value of ten for every motor. Configuration is always ready.
module quad_motor_stick_mixer #(
    parameter int SAMPLE_BITS = qmsm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [qmsm_pkg::ACTION_W-1:0]       i_action,
    input  logic [SAMPLE_BITS-1:0]              i_hor_sample,
    input  logic [SAMPLE_BITS-1:0]              i_ver_sample,
    // Output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [qmsm_pkg::MIDX_W-1:0]         o_motor_index,
    output logic [qmsm_pkg::SPEED_W-1:0]        o_motor_speed,
    output logic                                o_last_of_run,
    // Configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [qmsm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [qmsm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // Configuration registers.
    logic [qmsm_pkg::DZ_W-1:0]    r_dz_above;
    logic [qmsm_pkg::DZ_W-1:0]    r_dz_below;
    logic [qmsm_pkg::GAIN_W-1:0]  r_gain;
    logic [qmsm_pkg::SPEED_W-1:0] r_climb;

    // Stage one: accepted item.
    logic                          r_s1_valid;
    logic [qmsm_pkg::ACTION_W-1:0] r_s1_action;
    logic [SAMPLE_BITS-1:0]        r_s1_hor;
    logic [SAMPLE_BITS-1:0]        r_s1_ver;

    // Stage two: action and registered corrections.
    logic                          r_s2_valid;
    logic [qmsm_pkg::ACTION_W-1:0] r_s2_action;
    qmsm_pkg::t_corr               r_s2_hor;
    qmsm_pkg::t_corr               r_s2_ver;

    qmsm_pkg::t_corr   hor_corr;
    qmsm_pkg::t_corr   ver_corr;
    qmsm_pkg::t_speeds mix_speeds;
    logic              mix_changed;
    logic              mix_load;
    logic              out_free;
    logic              s2_fire;
    logic              s2_free;
    logic              s1_adv;
    logic              in_accept;

    // Configuration writes.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dz_above <= qmsm_pkg::DZ_ABOVE_RST;
            r_dz_below <= qmsm_pkg::DZ_BELOW_RST;
            r_gain     <= qmsm_pkg::GAIN_RST;
            r_climb    <= qmsm_pkg::CLIMB_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                qmsm_pkg::CFG_DZ_ABOVE: r_dz_above <= i_cfg_data;
                qmsm_pkg::CFG_DZ_BELOW: r_dz_below <= i_cfg_data;
                qmsm_pkg::CFG_GAIN:     r_gain     <= i_cfg_data[qmsm_pkg::GAIN_W-1:0];
                qmsm_pkg::CFG_CLIMB:    r_climb    <= i_cfg_data[qmsm_pkg::SPEED_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Pipeline flow control.
    assign s2_fire    = r_s2_valid && !(mix_changed && !out_free);
    assign s2_free    = !r_s2_valid || s2_fire;
    assign s1_adv     = r_s1_valid && s2_free;
    assign o_in_stall = r_s1_valid && !s2_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_s2_valid <= 1'b1;
            end else if (s2_fire) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    // Stage payloads need no reset.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_action <= i_action;
            r_s1_hor    <= i_hor_sample;
            r_s1_ver    <= i_ver_sample;
        end
        if (s1_adv) begin
            r_s2_action <= r_s1_action;
            r_s2_hor    <= hor_corr;
            r_s2_ver    <= ver_corr;
        end
    end

    // Axis corrections.
    qmsm_axis #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_axis_hor (
        .i_sample   (r_s1_hor),
        .i_dz_above (r_dz_above),
        .i_dz_below (r_dz_below),
        .i_gain     (r_gain),
        .o_corr     (hor_corr)
    );

    qmsm_axis #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_axis_ver (
        .i_sample   (r_s1_ver),
        .i_dz_above (r_dz_above),
        .i_dz_below (r_dz_below),
        .i_gain     (r_gain),
        .o_corr     (ver_corr)
    );

    // Speed update.
    qmsm_mixer u_mixer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (s2_fire),
        .i_action  (r_s2_action),
        .i_hor     (r_s2_hor),
        .i_ver     (r_s2_ver),
        .i_climb   (r_climb),
        .o_changed (mix_changed),
        .o_load    (mix_load),
        .o_speeds  (mix_speeds)
    );

    // Command output.
    qmsm_out_seq u_out_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (mix_load),
        .i_speeds (mix_speeds),
        .i_stall  (i_out_stall),
        .o_valid  (o_out_valid),
        .o_index  (o_motor_index),
        .o_speed  (o_motor_speed),
        .o_last   (o_last_of_run),
        .o_free   (out_free)
    );

    // A run is never loaded over commands still waiting.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mix_load |-> out_free)
        else $error("command run loaded while output buffer busy");

    // Within a run the motor index steps by one on each transfer.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last_of_run) |=>
            (o_out_valid && o_motor_index == $past(o_motor_index) + 1'b1))
        else $error("command run broken before its last motor");

    // An item held in stage two stays there until it fires.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !s2_fire) |=> (r_s2_valid && $stable(r_s2_action)))
        else $error("stage two item lost while held");

endmodule
